[hdl/sst_pkg.sv]
// shared types and constants for the two-sensor speed trap
`default_nettype none
package sst_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int TIME_BITS    = 32;
   localparam int THRESH_BITS  = 12;
   localparam int TIMEOUT_BITS = 16;
   localparam int COOL_BITS    = 16;
   localparam int DIST_BITS    = 14;
   localparam int TRANSIT_BITS = 16;
   localparam int MPS_BITS     = 20;
   localparam int KMH_BITS     = 22;
   localparam int QUOT_BITS    = 23;
   localparam int COUNT_BITS   = $clog2(QUOT_BITS);

   localparam int REQ_FIELD_BITS = 2 * SAMPLE_BITS + TIME_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = TRANSIT_BITS + MPS_BITS + KMH_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_BITS = 8;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_MS        = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COOLDOWN_MS       = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GATE_DISTANCE_MM  = 2'd3;

   localparam logic [THRESH_BITS-1:0]  THRESH_RESET  = 12'd2000;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd5000;
   localparam logic [COOL_BITS-1:0]    COOL_RESET    = 16'd1000;
   localparam logic [DIST_BITS-1:0]    DIST_RESET    = 14'd500;

   localparam logic [QUOT_BITS-1:0] MPS_SCALE = 23'd100;
   localparam logic [QUOT_BITS-1:0] KMH_SCALE = 23'd360;
   localparam logic [QUOT_BITS-1:0] MPS_MAX   = 23'd1000000;
   localparam logic [QUOT_BITS-1:0] KMH_MAX   = 23'd3600000;

   localparam logic EVENT_MEASURED = 1'b0;
   localparam logic EVENT_TIMEOUT  = 1'b1;

   typedef struct packed {
      logic [THRESH_BITS-1:0]  trigger_threshold;
      logic [TIMEOUT_BITS-1:0] timeout_ms;
      logic [COOL_BITS-1:0]    cooldown_ms;
      logic [DIST_BITS-1:0]    gate_distance_mm;
   } cfg_type;

   typedef struct packed {
      logic                    event_kind;
      logic [TRANSIT_BITS-1:0] transit_ms;
      logic                    speed_valid;
      logic [MPS_BITS-1:0]     speed_centi_mps;
      logic [KMH_BITS-1:0]     speed_centi_kmh;
   } result_type;

   typedef struct packed {
      logic                    start;
      logic [QUOT_BITS-1:0]    dividend;
      logic [TRANSIT_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [QUOT_BITS-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

[hdl/sst_div.sv]
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module sst_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sst_pkg::div_req_type div_req,
   output sst_pkg::div_rsp_type      div_rsp
);
   import sst_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [QUOT_BITS-1:0]    work_ff, work_in;
   logic [TRANSIT_BITS-1:0] rem_ff, rem_in;
   logic [TRANSIT_BITS-1:0] divisor_ff, divisor_in;
   logic [TRANSIT_BITS:0]   rem_shift;
   logic [TRANSIT_BITS:0]   diff;
   logic                    fits;

   // trial subtract of the shifted remainder
   assign rem_shift = {rem_ff, work_ff[QUOT_BITS-1]};
   assign diff      = rem_shift - {1'b0, divisor_ff};
   assign fits      = rem_shift >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (busy_ff) begin
         work_in  = {work_ff[QUOT_BITS-2:0], fits};
         rem_in   = fits ? diff[TRANSIT_BITS-1:0] : rem_shift[TRANSIT_BITS-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == COUNT_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

endmodule
`default_nettype wire

[hdl/sst_ctrl.sv]
// trap phase tracking and result sequencer driving the shared divider
`default_nettype none
module sst_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sst_pkg::cfg_type                     cfg,
   input  wire logic                                 req_fire,
   input  wire logic [sst_pkg::SAMPLE_BITS-1:0]      first_sample,
   input  wire logic [sst_pkg::SAMPLE_BITS-1:0]      second_sample,
   input  wire logic [sst_pkg::TIME_BITS-1:0]        now_ms,
   input  wire logic                                 out_free,
   input  wire sst_pkg::div_rsp_type                 div_rsp,
   output sst_pkg::div_req_type                      div_req,
   output logic                                      req_ready,
   output logic                                      push,
   output sst_pkg::result_type                       result
);
   import sst_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_WAIT = 3'b010,
      PH_COOL = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_MPS  = 4'b0010,
      SEQ_KMH  = 4'b0100,
      SEQ_PUSH = 4'b1000
   } seq_type;

   phase_type             phase_ff, phase_in;
   seq_type               seq_ff, seq_in;
   logic [TIME_BITS-1:0]  start_ff, start_in;
   logic [TIME_BITS-1:0]  cool_ff, cool_in;
   result_type            result_ff, result_in;
   logic [TIME_BITS-1:0]  elapsed;
   logic [TIME_BITS-1:0]  cool_gap;
   logic                  timed_out;
   logic [QUOT_BITS-1:0]  dist_ext;

   function automatic logic [QUOT_BITS-1:0] clamp(input logic [QUOT_BITS-1:0] q,
                                                  input logic [QUOT_BITS-1:0] cap);
      clamp = (q > cap) ? cap : q;
   endfunction

   // wrap-safe time differences
   assign elapsed   = now_ms - start_ff;
   assign cool_gap  = now_ms - cool_ff;
   assign timed_out = elapsed > TIME_BITS'(cfg.timeout_ms);
   assign dist_ext  = QUOT_BITS'(cfg.gate_distance_mm);

   always_comb begin
      phase_in = phase_ff;
      seq_in   = seq_ff;
      start_in = start_ff;
      cool_in  = cool_ff;
      result_in = result_ff;
      div_req.start    = 1'b0;
      div_req.dividend = dist_ext * MPS_SCALE;
      div_req.divisor  = result_ff.transit_ms;
      push = 1'b0;
      case (seq_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               case (phase_ff)
                  PH_WAIT: begin
                     if (timed_out) begin
                        result_in = '0;
                        result_in.event_kind = EVENT_TIMEOUT;
                        phase_in = PH_IDLE;
                        seq_in   = SEQ_PUSH;
                     end else if (second_sample > cfg.trigger_threshold) begin
                        result_in = '0;
                        result_in.event_kind = EVENT_MEASURED;
                        result_in.transit_ms = elapsed[TRANSIT_BITS-1:0];
                        cool_in  = now_ms + TIME_BITS'(cfg.cooldown_ms);
                        phase_in = PH_COOL;
                        if (elapsed != '0) begin
                           result_in.speed_valid = 1'b1;
                           div_req.start   = 1'b1;
                           div_req.divisor = elapsed[TRANSIT_BITS-1:0];
                           seq_in = SEQ_MPS;
                        end else begin
                           seq_in = SEQ_PUSH;
                        end
                     end
                  end
                  PH_COOL: begin
                     if (!cool_gap[TIME_BITS-1]) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     if (first_sample > cfg.trigger_threshold) begin
                        start_in = now_ms;
                        phase_in = PH_WAIT;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               endcase
            end
         end
         SEQ_MPS: begin
            if (div_rsp.done) begin
               result_in.speed_centi_mps = MPS_BITS'(clamp(div_rsp.quotient, MPS_MAX));
               div_req.start    = 1'b1;
               div_req.dividend = dist_ext * KMH_SCALE;
               seq_in = SEQ_KMH;
            end
         end
         SEQ_KMH: begin
            if (div_rsp.done) begin
               result_in.speed_centi_kmh = KMH_BITS'(clamp(div_rsp.quotient, KMH_MAX));
               seq_in = SEQ_PUSH;
            end
         end
         SEQ_PUSH: begin
            if (out_free) begin
               push   = 1'b1;
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         seq_ff   <= SEQ_IDLE;
         start_ff <= '0;
         cool_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         start_ff <= start_in;
         cool_ff  <= cool_in;
      end
      result_ff <= result_in;
   end

   assign req_ready = (seq_ff == SEQ_IDLE);
   assign result    = result_ff;

endmodule
`default_nettype wire

[hdl/two_sensor_speed_trap.sv]
// top level of the two-sensor speed trap timer
`default_nettype none
// Two-gate speed trap. Each req transaction carries a pair of sensor samples
// and a wrapping millisecond timestamp. The trap arms when the first sensor
// rises above trigger_threshold, then waits for the second sensor; a wait
// longer than timeout_ms gives a timeout result (tuser bit 0 set, all other
// fields zero). A second-sensor trigger gives the transit time and, for a
// nonzero transit, the speed in hundredths of m/s and km/h (truncated,
// saturated at 1000000 and 3600000), followed by a cooldown of cooldown_ms
// before the trap rearms. An item that yields no result, or a timeout or
// zero-transit result, does not use the divider; each result passes through
// the push state into the output register. A measurement with a speed runs
// the shared one-bit-per-cycle divider for two 23-step divisions back to
// back (m/s, then km/h). req_tready is low while an item is in the core; a
// finished result sits in the rsp output register and the core accepts new
// items meanwhile, stalling only when a second result is ready before the
// first has been taken. Configuration writes are always accepted and should
// be issued only while the trap is idle.
module two_sensor_speed_trap (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req transaction
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata fields from bit 0: first_sample, second_sample, now_ms
   input  wire logic [sst_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // rsp transaction
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata fields from bit 0: transit_ms, speed_centi_mps, speed_centi_kmh, zero pad
   output logic [sst_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata,
   // tuser fields from bit 0: event_kind, speed_valid, zero pad
   output logic [sst_pkg::RSP_TUSER_BITS-1:0]        rsp_tuser,
   // register write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sst_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [sst_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import sst_pkg::*;

   cfg_type                    cfg_ff, cfg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_result_ff, rsp_result_in;
   logic                       req_fire;
   logic                       out_free;
   logic                       push;
   result_type                 core_result;
   div_req_type                div_req;
   div_rsp_type                div_rsp;
   logic [SAMPLE_BITS-1:0]     first_sample;
   logic [SAMPLE_BITS-1:0]     second_sample;
   logic [TIME_BITS-1:0]       now_ms;

   // unpack request fields, lowest first
   assign first_sample  = req_tdata[SAMPLE_BITS-1:0];
   assign second_sample = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign now_ms        = req_tdata[REQ_FIELD_BITS-1:2*SAMPLE_BITS];

   assign req_fire = req_tvalid && req_tready;
   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // register file, writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRIGGER_THRESHOLD: cfg_in.trigger_threshold = csr_data[THRESH_BITS-1:0];
            CSR_TIMEOUT_MS:        cfg_in.timeout_ms        = csr_data[TIMEOUT_BITS-1:0];
            CSR_COOLDOWN_MS:       cfg_in.cooldown_ms       = csr_data[COOL_BITS-1:0];
            CSR_GATE_DISTANCE_MM:  cfg_in.gate_distance_mm  = csr_data[DIST_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // result output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = core_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_threshold <= THRESH_RESET;
         cfg_ff.timeout_ms        <= TIMEOUT_RESET;
         cfg_ff.cooldown_ms       <= COOL_RESET;
         cfg_ff.gate_distance_mm  <= DIST_RESET;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
   end

   sst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_fire      (req_fire),
      .first_sample  (first_sample),
      .second_sample (second_sample),
      .now_ms        (now_ms),
      .out_free      (out_free),
      .div_rsp       (div_rsp),
      .div_req       (div_req),
      .req_ready     (req_tready),
      .push          (push),
      .result        (core_result)
   );

   sst_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_BITS - RSP_FIELD_BITS)'(0),
                        rsp_result_ff.speed_centi_kmh,
                        rsp_result_ff.speed_centi_mps,
                        rsp_result_ff.transit_ms};
   assign rsp_tuser  = {(RSP_TUSER_BITS - 2)'(0),
                        rsp_result_ff.speed_valid,
                        rsp_result_ff.event_kind};

endmodule
`default_nettype wire

[hdl/sst_checker.sv]
// port-level checks for the speed trap, bound to the top level
`default_nettype none
module sst_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [sst_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   input wire logic [sst_pkg::RSP_TUSER_BITS-1:0]   rsp_tuser
);
   import sst_pkg::*;

   localparam int MPS_LSB = TRANSIT_BITS;
   localparam int KMH_LSB = TRANSIT_BITS + MPS_BITS;

   logic                    kind;
   logic                    spd_ok;
   logic [TRANSIT_BITS-1:0] transit;
   logic [MPS_BITS-1:0]     mps;
   logic [KMH_BITS-1:0]     kmh;

   assign kind    = rsp_tuser[0];
   assign spd_ok  = rsp_tuser[1];
   assign transit = rsp_tdata[TRANSIT_BITS-1:0];
   assign mps     = rsp_tdata[MPS_LSB+MPS_BITS-1:MPS_LSB];
   assign kmh     = rsp_tdata[KMH_LSB+KMH_BITS-1:KMH_LSB];

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // timeout result carries no transit and no speed
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind |-> !spd_ok && transit == '0 && mps == '0 && kmh == '0)
      else $error("timeout result with nonzero fields");

   // speed flag follows a nonzero transit on a measurement
   a_speed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !kind |-> spd_ok == (transit != '0))
      else $error("speed flag disagrees with transit");

   // speeds are cleared when not valid and stay within range when valid
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (spd_ok || (mps == '0 && kmh == '0)) &&
                     MPS_BITS'(mps) <= MPS_BITS'(MPS_MAX) &&
                     KMH_BITS'(kmh) <= KMH_BITS'(KMH_MAX))
      else $error("speed fields out of range");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind two_sensor_speed_trap sst_checker u_sst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
